### rtl/core/cwr_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the text console character writer
// no dependencies

package cwr_pkg;

  // fixed field widths of the beats
  localparam int CHAR_W     = 8;
  localparam int READ_COL_W = 7;
  localparam int READ_ROW_W = 5;
  localparam int CUR_COL_W  = 7;
  localparam int CUR_ROW_W  = 5;

  // character codes
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [CHAR_W-1:0] NULL_CODE    = 8'h00;

  // operation codes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // one result beat
  typedef struct packed {
    logic [CUR_COL_W-1:0] cursor_col;
    logic [CUR_ROW_W-1:0] cursor_row;
    logic                 screen_cleared;
    logic [CHAR_W-1:0]    cell_char;
  } cwr_result_t;

endpackage

### rtl/core/cwr_in_if.sv
`timescale 1ns / 1ps
// input channel of the console writer: valid/ready plus the item fields
// depends on cwr_pkg

interface cwr_in_if
  import cwr_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [CHAR_W-1:0]     char_code;
  logic [READ_COL_W-1:0] read_col;
  logic [READ_ROW_W-1:0] read_row;

  modport source (output valid, output op, output char_code, output read_col,
                  output read_row, input ready);
  modport sink   (input valid, input op, input char_code, input read_col,
                  input read_row, output ready);
endinterface

### rtl/core/cwr_out_if.sv
`timescale 1ns / 1ps
// result channel of the console writer: valid/ready plus the result fields
// depends on cwr_pkg

interface cwr_out_if
  import cwr_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CUR_COL_W-1:0] cursor_col;
  logic [CUR_ROW_W-1:0] cursor_row;
  logic                 screen_cleared;
  logic [CHAR_W-1:0]    cell_char;

  modport source (output valid, output cursor_col, output cursor_row,
                  output screen_cleared, output cell_char, input ready);
  modport sink   (input valid, input cursor_col, input cursor_row,
                  input screen_cleared, input cell_char, output ready);
endinterface

### rtl/core/cwr_grid_ram.sv
`timescale 1ns / 1ps
// character grid storage: one write port, one read port with registered data
// depends on cwr_pkg

module cwr_grid_ram
  import cwr_pkg::*;
#(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [CHAR_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [CHAR_W-1:0] rd_data
);

  logic [CHAR_W-1:0] mem [DEPTH];
  logic [CHAR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/cwr_ctrl.sv
`timescale 1ns / 1ps
// sequencer of the console writer: cursor, grid accesses and clearing sweep
// depends on cwr_pkg, cwr_in_if

module cwr_ctrl
  import cwr_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int CELLS   = 2000,
  parameter int AW      = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  cwr_in_if.sink            in_ch,
  output logic              mem_wr_en,
  output logic [AW-1:0]     mem_wr_addr,
  output logic [CHAR_W-1:0] mem_wr_data,
  output logic              mem_rd_en,
  output logic [AW-1:0]     mem_rd_addr,
  input  logic [CHAR_W-1:0] mem_rd_data,
  output logic              res_valid,
  output cwr_result_t       res,
  input  logic              res_take
);

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_RESP} state_t;

  state_t        state_r,     state_nxt;
  logic [CW-1:0] col_r,       col_nxt;
  logic [RW-1:0] row_r,       row_nxt;
  logic [AW-1:0] addr_r,      addr_nxt;
  logic [AW-1:0] base_r,      base_nxt;
  logic [AW-1:0] clr_addr_r,  clr_addr_nxt;
  logic          cleared_r,   cleared_nxt;
  logic          rd_ok_r,     rd_ok_nxt;

  logic          accept;
  logic          is_put;
  logic          is_newline;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic          wrap_col;
  logic          wrap_row;
  logic          rd_in_range;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_put      = (in_ch.op == OP_PUT) && (in_ch.char_code != NULL_CODE);
  assign is_newline  = (in_ch.char_code == NEWLINE_CODE);
  assign col_inc     = {1'b0, col_r} + 1'b1;
  assign row_inc     = {1'b0, row_r} + 1'b1;
  assign wrap_col    = is_newline || (32'(col_inc) == COLUMNS);
  assign wrap_row    = wrap_col && (32'(row_inc) == ROWS);
  assign rd_in_range = (32'(in_ch.read_col) < COLUMNS) && (32'(in_ch.read_row) < ROWS);

  // grid port: sweep writes spaces, a put of any byte but null or newline writes at the cursor
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = addr_r;
    mem_wr_data = in_ch.char_code;
    if (state_r == S_CLEAR) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_addr_r;
      mem_wr_data = SPACE_CODE;
    end else if (accept && is_put && !is_newline) begin
      mem_wr_en = 1'b1;
    end
  end

  assign mem_rd_en   = accept && (in_ch.op == OP_READ);
  assign mem_rd_addr = AW'(32'(in_ch.read_row) * 32'(COLUMNS) + 32'(in_ch.read_col));

  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    addr_nxt     = addr_r;
    base_nxt     = base_r;
    clr_addr_nxt = clr_addr_r;
    cleared_nxt  = cleared_r;
    rd_ok_nxt    = rd_ok_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (32'(clr_addr_r) == CELLS - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt   = S_RESP;
          cleared_nxt = 1'b0;
          rd_ok_nxt   = (in_ch.op == OP_READ) && rd_in_range;
          if (is_put) begin
            if (wrap_row) begin
              col_nxt     = '0;
              row_nxt     = '0;
              addr_nxt    = '0;
              base_nxt    = '0;
              cleared_nxt = 1'b1;
            end else if (wrap_col) begin
              col_nxt  = '0;
              row_nxt  = row_inc[RW-1:0];
              base_nxt = AW'(32'(base_r) + 32'(COLUMNS));
              addr_nxt = AW'(32'(base_r) + 32'(COLUMNS));
            end else begin
              col_nxt  = col_inc[CW-1:0];
              addr_nxt = addr_r + 1'b1;
            end
          end
        end
      end
      S_RESP: begin
        if (res_take) begin
          clr_addr_nxt = '0;
          state_nxt    = cleared_r ? S_CLEAR : S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      col_r      <= '0;
      row_r      <= '0;
      addr_r     <= '0;
      base_r     <= '0;
      clr_addr_r <= '0;
      cleared_r  <= 1'b0;
      rd_ok_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      addr_r     <= addr_nxt;
      base_r     <= base_nxt;
      clr_addr_r <= clr_addr_nxt;
      cleared_r  <= cleared_nxt;
      rd_ok_r    <= rd_ok_nxt;
    end
  end

  assign res_valid          = (state_r == S_RESP);
  assign res.cursor_col     = CUR_COL_W'(col_r);
  assign res.cursor_row     = CUR_ROW_W'(row_r);
  assign res.screen_cleared = cleared_r;
  assign res.cell_char      = rd_ok_r ? mem_rd_data : NULL_CODE;

endmodule

### rtl/core/text_console_character_writer.sv
`timescale 1ns / 1ps
// top level of the text console character writer
// depends on cwr_pkg, cwr_in_if, cwr_out_if, cwr_grid_ram, cwr_ctrl

// Keeps a COLUMNS x ROWS grid of character bytes in one synchronous RAM plus
// a cursor. A put beat with a newline moves the cursor to column 0 of the
// next row, a null byte does nothing, and any other byte is written at the
// cursor which then advances, wrapping to the next row at the last column.
// Stepping past the last row blanks the grid and homes the cursor; such a
// result beat carries screen_cleared. A read beat returns the byte at
// (read_col, read_row), or 0 outside the grid, with the cursor unchanged.
// Each item is accepted in S_IDLE and answered from S_RESP with the registered
// RAM read, one item in flight at a time; the next item is taken while the
// previous result still waits in the output register. After reset, and after
// every put that clears the screen, the grid is swept with spaces one cell per
// cycle; in_ch.ready stays low over all COLUMNS*ROWS cells (2000 at 80 x 25).

module text_console_character_writer
  import cwr_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic      clk,
  input  logic      rst_n,
  cwr_in_if.sink    in_ch,
  cwr_out_if.source out_ch
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  // grid ram port
  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  logic [CHAR_W-1:0] mem_wr_data;
  logic              mem_rd_en;
  logic [AW-1:0]     mem_rd_addr;
  logic [CHAR_W-1:0] mem_rd_data;

  // result handed from the sequencer to the output register
  logic        res_valid;
  cwr_result_t res;
  logic        res_take;

  // output register, parts the sequencer from the result channel
  logic        out_valid_r, out_valid_nxt;
  cwr_result_t out_res_r,   out_res_nxt;

  cwr_grid_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_grid_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  cwr_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .CELLS   (CELLS),
    .AW      (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .res_valid   (res_valid),
    .res         (res),
    .res_take    (res_take)
  );

  // take a result when the output register is empty or draining this cycle
  assign res_take = res_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.cursor_col     = out_res_r.cursor_col;
  assign out_ch.cursor_row     = out_res_r.cursor_row;
  assign out_ch.screen_cleared = out_res_r.screen_cleared;
  assign out_ch.cell_char      = out_res_r.cell_char;

endmodule

### rtl/core/cwr_checker.sv
`timescale 1ns / 1ps
// port-level checks of the console writer, bound to the top level
// depends on cwr_pkg, text_console_character_writer

module cwr_checker
  import cwr_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [CUR_COL_W-1:0] cursor_col,
  input logic [CUR_ROW_W-1:0] cursor_row,
  input logic                 screen_cleared
);

  // a waiting result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn before it was taken");

  // reset starts the blanking sweep and empties the output register
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("block not sweeping or result pending after reset");

  // a clearing put always homes the cursor
  a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && screen_cleared |-> cursor_col == '0 && cursor_row == '0)
    else $error("screen cleared but cursor not at home");

  // the cursor never leaves the grid
  a_cursor_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(cursor_col) < COLUMNS && 32'(cursor_row) < ROWS)
    else $error("cursor reported outside the grid");

endmodule

bind text_console_character_writer cwr_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_cwr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .cursor_col     (out_ch.cursor_col),
  .cursor_row     (out_ch.cursor_row),
  .screen_cleared (out_ch.screen_cleared)
);

### bench/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for text_console_character_writer: puts, reads, wraps and clears
// depends on cwr_pkg, cwr_in_if, cwr_out_if and the rtl top level

module tb_top
  import cwr_pkg::*;
();

  // grid size as built, defaults of the block
  localparam int GRID_COLS   = 80;
  localparam int GRID_ROWS   = 25;
  localparam int CELLS       = GRID_COLS * GRID_ROWS;
  // slowest honest run: every clear sweeps all CELLS cells, each beat waits out
  // the longest random gap on both sides, plus one long hold-off; taken several times over
  localparam int CYCLE_LIMIT = 400_000;
  localparam int HOLD_LEN    = 300;
  localparam int DRAIN_WAIT  = 8;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst_n;

  cwr_in_if  in_ch ();
  cwr_out_if out_ch ();

  text_console_character_writer #(
    .COLUMNS(GRID_COLS),
    .ROWS   (GRID_ROWS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // shadow copy of the console: grid bytes and cursor
  logic [CHAR_W-1:0] grid_shadow [CELLS];
  int                cur_col;
  int                cur_row;

  // results still owed by the block, oldest first
  cwr_result_t pending_results[$];

  int  mismatches  = 0;
  int  cycle_count = 0;
  bit  idle_en     = 1'b1;  // random gaps and stalls on both sides
  int  hold_asks   = 0;     // bumped by a test to request one long hold-off
  int  items_sent  = 0;

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  function automatic void console_blank();
    for (int i = 0; i < CELLS; i++) grid_shadow[i] = SPACE_CODE;
  endfunction

  // applies one item to the shadow console and returns the result beat it causes
  function automatic cwr_result_t console_update(logic op, logic [CHAR_W-1:0] code,
                                                 logic [READ_COL_W-1:0] rcol,
                                                 logic [READ_ROW_W-1:0] rrow);
    cwr_result_t res;
    res = '0;
    if (op == OP_READ) begin
      // outside the grid the cell reads as zero
      if (rcol < GRID_COLS && rrow < GRID_ROWS)
        res.cell_char = grid_shadow[int'(rrow) * GRID_COLS + int'(rcol)];
    end else if (code != NULL_CODE) begin
      if (code == NEWLINE_CODE) begin
        cur_col = 0;
        cur_row++;
      end else begin
        grid_shadow[cur_row * GRID_COLS + cur_col] = code;
        cur_col++;
      end
      // wrap at the last column
      if (cur_col >= GRID_COLS) begin
        cur_col = 0;
        cur_row++;
      end
      // stepping past the last row blanks everything and homes the cursor
      if (cur_row >= GRID_ROWS) begin
        cur_col = 0;
        cur_row = 0;
        console_blank();
        res.screen_cleared = 1'b1;
      end
    end
    res.cursor_col = cur_col[CUR_COL_W-1:0];
    res.cursor_row = cur_row[CUR_ROW_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // sender side: one beat per call, optional idle burst first
  // ---------------------------------------------------------------------

  task automatic send_beat(logic op, logic [CHAR_W-1:0] code,
                           logic [READ_COL_W-1:0] rcol, logic [READ_ROW_W-1:0] rrow);
    int gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid     = 1'b1;
    in_ch.op        = op;
    in_ch.char_code = code;
    in_ch.read_col  = rcol;
    in_ch.read_row  = rrow;
    // hold the beat until the block takes it
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_results.push_back(console_update(op, code, rcol, rrow));
    items_sent++;
  endtask

  // put items carry junk in the read fields, reads carry junk in char_code
  task automatic send_put(logic [CHAR_W-1:0] code);
    send_beat(OP_PUT, code, READ_COL_W'($urandom), READ_ROW_W'($urandom));
  endtask

  task automatic send_read(int col, int row);
    send_beat(OP_READ, CHAR_W'($urandom), READ_COL_W'(col), READ_ROW_W'(row));
  endtask

  // ---------------------------------------------------------------------
  // receiver side: random stall bursts plus the requested long hold-off
  // ---------------------------------------------------------------------

  int stall_left = 0;
  int hold_left  = 0;
  int hold_seen  = 0;

  always @(negedge clk) begin
    if (hold_asks != hold_seen) begin
      // long hold-off so the block fills and back-pressures its input
      hold_seen    = hold_asks;
      hold_left    = HOLD_LEN - 1;
      out_ch.ready = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready = 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left   = $urandom_range(1, 4) - 1;
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // result checker: each accepted beat against the oldest expectation
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    cwr_result_t got;
    cwr_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.cursor_col     = out_ch.cursor_col;
      got.cursor_row     = out_ch.cursor_row;
      got.screen_cleared = out_ch.screen_cleared;
      got.cell_char      = out_ch.cell_char;
      if (pending_results.size() == 0) begin
        // a beat nobody asked for
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] unexpected result beat: col %0d row %0d clr %0b char %02h",
                   $realtime, got.cursor_col, got.cursor_row, got.screen_cleared,
                   got.cell_char);
      end else begin
        want = pending_results.pop_front();
        if (got.cursor_col !== want.cursor_col || got.cursor_row !== want.cursor_row ||
            got.screen_cleared !== want.screen_cleared ||
            got.cell_char !== want.cell_char) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] expected %0d,%0d clr %0b char %02h, got %0d,%0d clr %0b char %02h",
                     $realtime,
                     want.cursor_col, want.cursor_row, want.screen_cleared,
                     want.cell_char, got.cursor_col, got.cursor_row,
                     got.screen_cleared, got.cell_char);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // grid comes out of reset blank: corners read as spaces
  task automatic test_reset_state();
    send_read(0, 0);
    send_read(GRID_COLS - 1, GRID_ROWS - 1);
  endtask

  // plain puts incl. top-bit bytes, a null byte and a newline, then read back
  task automatic test_put_and_read();
    send_put(8'h48);
    send_put(8'hFF);
    send_put(8'h80);
    send_put(NULL_CODE);      // empty string, cursor must stay
    send_put(8'h01);
    send_put(8'h7F);
    send_put(NEWLINE_CODE);
    send_put(8'h5A);
    send_read(0, 0);
    send_read(1, 0);
    send_read(2, 0);
    send_read(3, 0);
    send_read(4, 0);
    send_read(0, 1);
  endtask

  // reads beyond the last column or row give zero
  task automatic test_out_of_grid();
    send_read(GRID_COLS, 0);
    send_read(0, GRID_ROWS);
    send_read((1 << READ_COL_W) - 1, (1 << READ_ROW_W) - 1);
  endtask

  // newlines down past the last row: grid blanks and cursor homes
  task automatic test_screen_clear();
    int need;
    need = GRID_ROWS - cur_row;
    repeat (need) send_put(NEWLINE_CODE);
    send_read(0, 0);
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    hold_asks++;
    repeat (20) send_put(CHAR_W'($urandom_range(32, 126)));
    send_read(0, cur_row);
  endtask

  // one random character for text: mostly printable, some odd bytes
  function automatic logic [CHAR_W-1:0] text_char();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return NULL_CODE;
    if (r == 1) return CHAR_W'($urandom_range(128, 255));
    if (r == 2) return CHAR_W'($urandom_range(1, 31));
    return CHAR_W'($urandom_range(32, 126));
  endfunction

  // well-formed text lines with random content, read-backs near the cursor,
  // bursts of newlines to reach the clear, and a share of raw noise
  task automatic test_random_text(int n_items);
    int stop_at;
    int kind;
    int len;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
        // a line; now and then long enough to wrap past the last column
        if ($urandom_range(0, 7) == 0) len = $urandom_range(GRID_COLS - 6, GRID_COLS + 6);
        else len = $urandom_range(0, 6);
        repeat (len) send_put(text_char());
        if ($urandom_range(0, 4) != 0) send_put(NEWLINE_CODE);
      end else if (kind <= 6) begin
        // read back cells most likely written so far
        repeat ($urandom_range(1, 4))
          send_read($urandom_range(0, 10), $urandom_range(0, cur_row));
      end else if (kind == 7) begin
        repeat ($urandom_range(3, 12)) send_put(NEWLINE_CODE);
      end else begin
        // noise over the full field ranges
        repeat ($urandom_range(1, 4))
          send_beat(logic'($urandom), CHAR_W'($urandom), READ_COL_W'($urandom),
                    READ_ROW_W'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.op        = OP_PUT;
    in_ch.char_code = NULL_CODE;
    in_ch.read_col  = '0;
    in_ch.read_row  = '0;
    out_ch.ready    = 1'b1;
    console_blank();
    cur_col = 0;
    cur_row = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_put_and_read();
    test_out_of_grid();
    test_screen_clear();
    test_backpressure();
    test_random_text(400);
    // last stretch runs flat out on both sides
    idle_en = 1'b0;
    test_random_text(100);

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
